// ----- rtl/cell_binning_center_of_mass_top_macros.svh -----
// Assertion macros used by the cell binning center-of-mass top level.
// Depends on nothing; the including module provides clk_i and rst_ni.
`ifndef CELL_BINNING_CENTER_OF_MASS_TOP_MACROS_SVH
`define CELL_BINNING_CENTER_OF_MASS_TOP_MACROS_SVH

// Checked on every rising edge outside of reset.
`define CBCOM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define CBCOM_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/cbcom_pkg.sv -----
// Types and constants of the cell binning center-of-mass block.
// Used by the top level and the divider; depends on nothing.
package cbcom_pkg;

  localparam int unsigned POS_W   = 16;
  localparam int unsigned MASS_W  = 32;
  localparam int unsigned WSUM_W  = 48;
  localparam int unsigned CEN_W   = 16;
  localparam int unsigned CFG_W   = 5;
  localparam int unsigned IDX_W   = 8;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd4;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [15:0]      mass;
    logic [IDX_W-1:0] cell_select;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  cell_index;
    logic [MASS_W-1:0] cell_mass;
    logic [CEN_W-1:0]  center_x;
    logic [CEN_W-1:0]  center_y;
    logic              cell_empty;
    logic              overflow;
  } out_item_t;

  // One memory word per cell.
  typedef struct packed {
    logic [MASS_W-1:0] mass;
    logic [WSUM_W-1:0] wx;
    logic [WSUM_W-1:0] wy;
  } cell_entry_t;

endpackage

// ----- rtl/cbcom_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module cbcom_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/cbcom_div.sv -----
// Radix-2 restoring divider: 48-bit dividend over 32-bit divisor, 16-bit
// clamped quotient and 32-bit remainder. Depends on cbcom_pkg.
module cbcom_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [cbcom_pkg::WSUM_W-1:0] num_i,
  input  logic [cbcom_pkg::MASS_W-1:0] den_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic [cbcom_pkg::CEN_W-1:0]  quo_o,
  output logic [cbcom_pkg::MASS_W-1:0] rem_o
);
  import cbcom_pkg::*;

  localparam int unsigned CW = $clog2(CEN_W + 1);

  logic [MASS_W-1:0] rem_q, rem_d, den_q;
  logic [CEN_W-1:0]  lo_q, quo_q;
  logic [CW-1:0]     cnt_q;
  logic              busy_q, done_q;
  logic [MASS_W:0]   trial;
  logic              ge;

  // When the upper dividend bits already reach the divisor the quotient
  // does not fit and is clamped to all ones.
  always_comb begin
    trial = {rem_q, lo_q[CEN_W-1]};
    ge    = trial >= {1'b0, den_q};
    rem_d = ge ? MASS_W'(trial - {1'b0, den_q}) : trial[MASS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        den_q <= den_i;
        if (num_i[WSUM_W-1:CEN_W] >= den_i) begin
          quo_q  <= '1;
          rem_q  <= '0;
          done_q <= 1'b1;
          busy_q <= 1'b0;
        end else begin
          rem_q  <= num_i[WSUM_W-1:CEN_W];
          lo_q   <= num_i[CEN_W-1:0];
          cnt_q  <= CW'(CEN_W);
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        rem_q <= rem_d;
        lo_q  <= {lo_q[CEN_W-2:0], 1'b0};
        quo_q <= {quo_q[CEN_W-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ----- rtl/cell_binning_center_of_mass_top.sv -----
// A center quotient that clamps skips the divider's steps, and an out-of-range read skips the
// memory and the dividers; a stalled result waits in place.
// One transaction is in flight and the next is accepted once the result is registered; an add
// and a read both wait on the two 16-step dividers and the memory access.
// A clear command and reset sweep the cell memory one entry a cycle, MAX_CELLS_PER_SIDE squared
// entries (256 by default); nothing is accepted then. Reset sets the register to 4 cells a side.
`include "cell_binning_center_of_mass_top_macros.svh"
module cell_binning_center_of_mass_top #(
  parameter int unsigned MAX_CELLS_PER_SIDE = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  cbcom_pkg::in_item_t          in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output cbcom_pkg::out_item_t         out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [cbcom_pkg::CFG_W-1:0]  cfg_data_i
);
  import cbcom_pkg::*;

  // Cell count and the widths that follow from it.
  localparam int unsigned NCELLS = MAX_CELLS_PER_SIDE * MAX_CELLS_PER_SIDE;
  localparam int unsigned IW     = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int unsigned NW     = $clog2(MAX_CELLS_PER_SIDE + 1);
  localparam int unsigned EW     = $bits(cell_entry_t);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_BIN, S_IDX, S_RDWAIT, S_UPD,
    S_SELDIV, S_LOAD, S_EVAL, S_DIV, S_DONE
  } state_e;

  state_e            state_q;
  logic [CFG_W-1:0]  cfg_q;
  logic [NW-1:0]     n_eff, n_q, col_q, row_q;
  logic [2*NW-1:0]   nn;
  logic [POS_W-1:0]  x_q, y_q;
  logic [15:0]       m_q;
  logic [IDX_W-1:0]  sel_q;
  logic [IW-1:0]     idx_q, clr_ptr_q;
  logic [MASS_W-1:0] mx_q, my_q;
  cell_entry_t       cur_q, rd_entry, upd_entry, wr_entry;
  logic              sat_q, oor_q, empty_q, xs_q, ys_q;
  out_item_t         out_q;
  logic              out_valid_q;

  // Divider lanes.
  logic              div_start_q;
  logic [WSUM_W-1:0] dx_num_q, dy_num_q;
  logic [MASS_W-1:0] dx_den_q, dy_den_q;
  logic              x_busy, y_busy, x_done, y_done;
  logic [CEN_W-1:0]  x_quo, y_quo;
  logic [MASS_W-1:0] x_rem, y_rem;

  // Memory port.
  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [EW-1:0]     ram_rdata;

  // Saturating update terms.
  logic [MASS_W:0]   msum;
  logic [WSUM_W:0]   xsum, ysum;
  logic              upd_sat;

  logic              in_acc, out_load;

  // A register value of zero acts as one cell; a value above the maximum is clamped.
  always_comb begin
    if (cfg_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(cfg_q) > MAX_CELLS_PER_SIDE) begin
      n_eff = NW'(MAX_CELLS_PER_SIDE);
    end else begin
      n_eff = NW'(cfg_q);
    end
    nn = n_eff * n_eff;
  end

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cfg_q <= cfg_data_i;
    end
  end

  // Read-modify-write of one cell. The accumulators saturate at all ones and any
  // saturation raises the sticky overflow flag.
  assign rd_entry = cell_entry_t'(ram_rdata);

  always_comb begin
    msum    = {1'b0, rd_entry.mass} + (MASS_W + 1)'(m_q);
    xsum    = {1'b0, rd_entry.wx} + (WSUM_W + 1)'(mx_q);
    ysum    = {1'b0, rd_entry.wy} + (WSUM_W + 1)'(my_q);
    upd_sat = msum[MASS_W] || xsum[WSUM_W] || ysum[WSUM_W];
    upd_entry.mass = msum[MASS_W] ? '1 : msum[MASS_W-1:0];
    upd_entry.wx   = xsum[WSUM_W] ? '1 : xsum[WSUM_W-1:0];
    upd_entry.wy   = ysum[WSUM_W] ? '1 : ysum[WSUM_W-1:0];
  end

  // The clearing sweep and the update step are the only writers. Since only one
  // transaction is in flight, a write always lands before the next read is issued.
  always_comb begin
    ram_we    = (state_q == S_CLEAR) || (state_q == S_UPD);
    ram_waddr = (state_q == S_CLEAR) ? clr_ptr_q : idx_q;
    wr_entry  = (state_q == S_CLEAR) ? '0 : upd_entry;
  end

  cbcom_ram #(
    .WIDTH(EW),
    .DEPTH(NCELLS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(wr_entry),
    .raddr_i(idx_q),
    .rdata_o(ram_rdata)
  );

  cbcom_div u_div_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start_q),
    .num_i  (dx_num_q),
    .den_i  (dx_den_q),
    .busy_o (x_busy),
    .done_o (x_done),
    .quo_o  (x_quo),
    .rem_o  (x_rem)
  );

  cbcom_div u_div_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start_q),
    .num_i  (dy_num_q),
    .den_i  (dy_den_q),
    .busy_o (y_busy),
    .done_o (y_done),
    .quo_o  (y_quo),
    .rem_o  (y_rem)
  );

  // Sequencer. An add bins the particle (one multiply stage, then the index
  // multiply-add), reads the cell, writes the updated sums back and then divides.
  // A read first splits the cell number into row and column with the x divider,
  // loads the cell and divides. An empty cell divides the geometric center
  // (2k+1)*2^15 by n instead of the weighted sums.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_ptr_q   <= '0;
      sat_q       <= 1'b0;
      div_start_q <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      div_start_q <= 1'b0;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          sat_q <= 1'b0;
          if (clr_ptr_q == IW'(NCELLS - 1)) begin
            state_q <= S_IDLE;
          end else begin
            clr_ptr_q <= clr_ptr_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            x_q   <= in_data_i.pos_x;
            y_q   <= in_data_i.pos_y;
            m_q   <= in_data_i.mass;
            sel_q <= in_data_i.cell_select;
            n_q   <= n_eff;
            oor_q <= 1'b0;
            case (in_data_i.opcode)
              OP_ADD: begin
                state_q <= S_BIN;
              end
              OP_READ: begin
                if (32'(in_data_i.cell_select) >= 32'(nn) ||
                    32'(in_data_i.cell_select) >= NCELLS) begin
                  oor_q   <= 1'b1;
                  state_q <= S_DONE;
                end else begin
                  idx_q       <= IW'(in_data_i.cell_select);
                  dx_num_q    <= WSUM_W'(in_data_i.cell_select);
                  dx_den_q    <= MASS_W'(n_eff);
                  dy_num_q    <= '0;
                  dy_den_q    <= MASS_W'(n_eff);
                  div_start_q <= 1'b1;
                  state_q     <= S_SELDIV;
                end
              end
              OP_CLEAR: begin
                clr_ptr_q <= '0;
                sat_q     <= 1'b0;
                state_q   <= S_CLEAR;
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_BIN: begin
          col_q   <= NW'((32'(x_q) * 32'(n_q)) >> POS_W);
          row_q   <= NW'((32'(y_q) * 32'(n_q)) >> POS_W);
          mx_q    <= 32'(m_q) * 32'(x_q);
          my_q    <= 32'(m_q) * 32'(y_q);
          state_q <= S_IDX;
        end
        S_IDX: begin
          if ((32'(row_q) * 32'(n_q) + 32'(col_q)) >= NCELLS) begin
            idx_q <= IW'(NCELLS - 1);
          end else begin
            idx_q <= IW'(32'(row_q) * 32'(n_q) + 32'(col_q));
          end
          state_q <= S_RDWAIT;
        end
        S_RDWAIT: begin
          state_q <= S_UPD;
        end
        S_UPD: begin
          cur_q   <= upd_entry;
          if (upd_sat) begin
            sat_q <= 1'b1;
          end
          state_q <= S_EVAL;
        end
        S_SELDIV: begin
          if (x_done) begin
            col_q   <= NW'(x_rem);
            row_q   <= NW'(x_quo);
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          cur_q   <= rd_entry;
          state_q <= S_EVAL;
        end
        S_EVAL: begin
          dx_den_q <= (cur_q.mass == '0) ? MASS_W'(n_q) : cur_q.mass;
          dy_den_q <= (cur_q.mass == '0) ? MASS_W'(n_q) : cur_q.mass;
          dx_num_q <= (cur_q.mass == '0) ? (WSUM_W'({col_q, 1'b1}) << (CEN_W - 1)) : cur_q.wx;
          dy_num_q <= (cur_q.mass == '0) ? (WSUM_W'({row_q, 1'b1}) << (CEN_W - 1)) : cur_q.wy;
          empty_q     <= (cur_q.mass == '0);
          div_start_q <= 1'b1;
          xs_q        <= 1'b0;
          ys_q        <= 1'b0;
          state_q     <= S_DIV;
        end
        S_DIV: begin
          if (x_done) begin
            xs_q <= 1'b1;
          end
          if (y_done) begin
            ys_q <= 1'b1;
          end
          if ((xs_q || x_done) && (ys_q || y_done)) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_valid_q <= 1'b1;
            out_q.overflow <= sat_q;
            if (oor_q) begin
              out_q.cell_index <= sel_q;
              out_q.cell_mass  <= '0;
              out_q.center_x   <= '0;
              out_q.center_y   <= '0;
              out_q.cell_empty <= 1'b1;
            end else begin
              out_q.cell_index <= IDX_W'(idx_q);
              out_q.cell_mass  <= cur_q.mass;
              out_q.center_x   <= x_quo;
              out_q.center_y   <= y_quo;
              out_q.cell_empty <= empty_q;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The memory is written only by the clearing sweep or the update step.
  `CBCOM_ASSERT(a_ram_we_src, ram_we |-> (state_q == S_CLEAR || state_q == S_UPD), "unexpected cell memory write")
  // A cell reported empty always carries zero mass.
  `CBCOM_ASSERT(a_empty_mass, out_valid_o |-> (!out_data_o.cell_empty || out_data_o.cell_mass == '0), "empty cell with nonzero mass")
  // Both dividers are idle whenever a new transaction can be accepted.
  `CBCOM_ASSERT(a_div_idle, (state_q == S_IDLE) |-> (!x_busy && !y_busy), "divider busy while idle")
  // The overflow flag is down for the whole clearing sweep after its first cycle.
  `CBCOM_ASSERT(a_clear_flag, (state_q == S_CLEAR && $past(state_q) == S_CLEAR) |-> !sat_q, "overflow flag set during clear")

endmodule

// ----- bench/cell_binning_center_of_mass_top_tb.sv -----
// Self-checking testbench for the cell binning center-of-mass block.
// Depends on cbcom_pkg and cell_binning_center_of_mass_top, and through it on cbcom_ram and cbcom_div.
`timescale 1ns / 100ps

module cell_binning_center_of_mass_top_tb;
  import cbcom_pkg::*;

  localparam int unsigned MAXN = 16;
  localparam int unsigned NCELL = MAXN * MAXN;
  localparam longint unsigned CYCLE_LIMIT = 1500000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i = '0;

  always #4 clk_i = ~clk_i;

  cell_binning_center_of_mass_top #(.MAX_CELLS_PER_SIDE(MAXN)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  // Shadow copy of the cell stores, the sticky flag and the register.
  longint unsigned shadow_mass[NCELL];
  longint unsigned shadow_wx[NCELL];
  longint unsigned shadow_wy[NCELL];
  bit shadow_sat;
  logic [CFG_W-1:0] shadow_cps;

  in_item_t pending_items[$];
  out_item_t expected_results[$];
  int unsigned mismatches = 0;
  bit failed = 0;
  longint unsigned cycle_count = 0;

  // Appends one transaction to the tail of the driver queue.
  function automatic void queue_item(in_item_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  // Appends one expected result to the tail of the scoreboard queue.
  function automatic void queue_expected(out_item_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic longint unsigned grid_n();
    if (shadow_cps == 0) return 1;
    if (shadow_cps > MAXN) return MAXN;
    return shadow_cps;
  endfunction

  function automatic longint unsigned sat_accum(longint unsigned a, longint unsigned b,
                                                longint unsigned lim);
    if (a > lim || b > lim - a) begin
      shadow_sat = 1'b1;
      return lim;
    end
    return a + b;
  endfunction

  function automatic logic [15:0] clamp_quot(longint unsigned w, longint unsigned m);
    longint unsigned q;
    q = w / m;
    return (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic logic [15:0] geometric_center(longint unsigned k, longint unsigned n);
    longint unsigned v;
    v = ((2 * k + 1) << 16) / (2 * n);
    return v[15:0];
  endfunction

  function automatic out_item_t cell_report(longint unsigned idx, longint unsigned n);
    out_item_t r;
    longint unsigned m;
    m = shadow_mass[idx];
    r.cell_index = idx[7:0];
    r.cell_mass = m[31:0];
    if (m == 0) begin
      r.center_x = geometric_center(idx % n, n);
      r.center_y = geometric_center(idx / n, n);
      r.cell_empty = 1'b1;
    end else begin
      r.center_x = clamp_quot(shadow_wx[idx], m);
      r.center_y = clamp_quot(shadow_wy[idx], m);
      r.cell_empty = 1'b0;
    end
    r.overflow = shadow_sat;
    return r;
  endfunction

  function automatic void clear_shadow();
    for (int i = 0; i < NCELL; i++) begin
      shadow_mass[i] = 0;
      shadow_wx[i] = 0;
      shadow_wy[i] = 0;
    end
    shadow_sat = 1'b0;
  endfunction

  // Applies one accepted transaction to the shadow state and queues its result, if it has one.
  function automatic void predict_cell_update(in_item_t it);
    longint unsigned n, col, row, idx, x, y, m;
    out_item_t r;
    n = grid_n();
    x = it.pos_x;
    y = it.pos_y;
    m = it.mass;
    case (it.opcode)
      OP_ADD: begin
        col = (x * n) >> 16;
        row = (y * n) >> 16;
        idx = row * n + col;
        if (idx >= NCELL) idx = NCELL - 1;
        shadow_mass[idx] = sat_accum(shadow_mass[idx], m, 64'hFFFF_FFFF);
        shadow_wx[idx] = sat_accum(shadow_wx[idx], m * x, 64'hFFFF_FFFF_FFFF);
        shadow_wy[idx] = sat_accum(shadow_wy[idx], m * y, 64'hFFFF_FFFF_FFFF);
        queue_expected(cell_report(idx, n));
      end
      OP_READ: begin
        if (it.cell_select >= n * n) begin
          r = '0;
          r.cell_index = it.cell_select;
          r.cell_empty = 1'b1;
          r.overflow = shadow_sat;
          queue_expected(r);
        end else begin
          queue_expected(cell_report(it.cell_select, n));
        end
      end
      OP_CLEAR: clear_shadow();
      default: ;
    endcase
  endfunction

  // Driver: bursts of transactions separated by random gaps. The valid line is lowered
  // only between bursts or when the queue runs dry, never while the payload is stalled.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  bit driving_on = 0;

  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      predict_cell_update(in_data_i);
    end
    if (!in_valid_i || !in_stall_o) begin
      if (driving_on && pending_items.size() != 0 && gap_left == 0) begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_items.pop_front();
        if (burst_left == 0) begin
          burst_left = $urandom_range(20, 1);
          gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
        if (gap_left != 0) gap_left--;
      end
    end
  end

  // Receiver stall pattern: long open stretches alternating with stall runs.
  int unsigned stall_phase = 0;
  always @(posedge clk_i) begin
    if (stall_phase == 0) begin
      stall_phase = $urandom_range(60, 1);
      out_stall_i <= ($urandom_range(2) != 0) ? 1'b0 : ~out_stall_i;
    end else begin
      stall_phase--;
      if (out_stall_i == 1'b0 && $urandom_range(9) == 0 && stall_phase % 2 == 1) begin
        out_stall_i <= 1'b1;
      end else if (out_stall_i && $urandom_range(3) == 0) begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    out_item_t exp_r;
    cycle_count++;
    if (out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        failed = 1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction %p", out_data_o);
      end else begin
        exp_r = expected_results.pop_front();
        if (out_data_o !== exp_r) begin
          failed = 1;
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected %p, got %p", exp_r, out_data_o);
          end
        end
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic in_item_t make_item(logic [1:0] op, logic [15:0] x, logic [15:0] y,
                                         logic [15:0] m, logic [7:0] sel);
    in_item_t it;
    it.opcode = op;
    it.pos_x = x;
    it.pos_y = y;
    it.mass = m;
    it.cell_select = sel;
    return it;
  endfunction

  function automatic in_item_t random_item();
    int unsigned pick;
    logic [15:0] m;
    pick = $urandom_range(99);
    m = ($urandom_range(4) == 0) ? 16'($urandom_range(3) * 16'h5555) : 16'($urandom);
    if (pick < 62) return make_item(OP_ADD, 16'($urandom), 16'($urandom), m, 8'($urandom));
    if (pick < 94) begin
      return make_item(OP_READ, 16'($urandom), 16'($urandom), m,
                       ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(15)));
    end
    if (pick < 97) return make_item(OP_UNUSED, 16'($urandom), 16'($urandom), m, 8'($urandom));
    return make_item(OP_CLEAR, 16'($urandom), 16'($urandom), m, 8'($urandom));
  endfunction

  // Lets the queue drain, then waits out any clear sweep before the next phase.
  task automatic settle();
    while (pending_items.size() != 0 || in_valid_i || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_cells_per_side(logic [CFG_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    shadow_cps = value;
  endtask

  logic [CFG_W-1:0] phase_settings[8] = '{5'd4, 5'd1, 5'd16, 5'd0, 5'd31, 5'd3, 5'd7, 5'd16};

  initial begin
    clear_shadow();
    shadow_cps = CFG_RESET;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (400) @(posedge clk_i);

    // Directed transactions at the reset setting: corners, extremes, repeated adds to one cell, a clear.
    queue_item(make_item(OP_READ, 16'h0, 16'h0, 16'h0, 8'd0));
    queue_item(make_item(OP_ADD, 16'h0, 16'h0, 16'h0, 8'd0));
    queue_item(make_item(OP_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
    queue_item(make_item(OP_ADD, 16'hFFFF, 16'h0, 16'h1, 8'h0));
    queue_item(make_item(OP_ADD, 16'h0, 16'hFFFF, 16'hFFFF, 8'h0));
    queue_item(make_item(OP_READ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd15));
    queue_item(make_item(OP_READ, 16'h0, 16'h0, 16'h0, 8'd16));
    queue_item(make_item(OP_READ, 16'h0, 16'h0, 16'h0, 8'hFF));
    queue_item(make_item(OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
    queue_item(make_item(OP_READ, 16'h0, 16'h0, 16'h0, 8'd5));
    for (int i = 0; i < 9; i++) begin
      queue_item(make_item(OP_ADD, 16'h8000, 16'h8000, 16'hFFFF, 8'd0));
    end
    queue_item(make_item(OP_READ, 16'h0, 16'h0, 16'h0, 8'd10));
    queue_item(make_item(OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
    queue_item(make_item(OP_READ, 16'h0, 16'h0, 16'h0, 8'd10));
    driving_on = 1;
    settle();

    // Random phases, each under its own register setting.
    foreach (phase_settings[p]) begin
      write_cells_per_side(phase_settings[p]);
      for (int i = 0; i < 116; i++) queue_item(random_item());
      settle();
    end

    if (!failed && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
